// File: src/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the burst byte ring buffer
// Transaction payloads, command codes, decoded operations and the back end
// state and status types.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int CAP_W  = 7;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic              burst_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [CAP_W-1:0]  actual_count;
        logic              accepted;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_TAKE,
        OP_PEEK
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  need;
        logic              burst_end;
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    typedef struct packed {
        logic [CAP_W-1:0] fill_count;
        logic [CAP_W-1:0] capacity;
        logic             reading;
    } t_back_status;

endpackage

// File: src/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram: simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/brb_front.sv
// ----------------------------------------------------------------------------
// brb_front: input decode and operation queue
// Accept input transactions, classify the command, drop unused codes and
// hold decoded operations in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module brb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  brb_pkg::t_in_item i_in_item,
    output logic              o_head_valid,
    output brb_pkg::t_op      o_head,
    input  logic              i_pop
);
    import brb_pkg::*;

    t_op        r_q [2];
    logic       r_wr_idx, n_wr_idx;
    logic       r_rd_idx, n_rd_idx;
    logic [1:0] r_count,  n_count;

    t_op  dec_op;
    logic dec_keep;
    logic push;

    // Classify the command; zero burst length counts as one byte
    always_comb begin
        dec_op           = '0;
        dec_keep         = 1'b1;
        dec_op.data_byte = i_in_item.data_byte;
        dec_op.length    = i_in_item.length;
        dec_op.need      = (i_in_item.length == '0) ? LEN_W'(1) : i_in_item.length;
        dec_op.burst_end = i_in_item.burst_end;
        case (i_in_item.command)
            CMD_APPEND: dec_op.kind = OP_APPEND;
            CMD_TAKE:   dec_op.kind = OP_TAKE;
            CMD_PEEK:   dec_op.kind = OP_PEEK;
            default:    dec_keep    = 1'b0;
        endcase
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign push         = i_in_valid && !o_in_stall && dec_keep;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_idx];

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (push) begin
            n_wr_idx = ~r_wr_idx;
        end
        if (i_pop) begin
            n_rd_idx = ~r_rd_idx;
        end
        case ({push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= dec_op;
        end
    end

endmodule

// File: src/brb_back.sv
// ----------------------------------------------------------------------------
// brb_back: ring buffer execution
// Carry out queued appends, takes and peeks against the byte store, track
// pointers, fill count and burst state, and drive the result register.
// ----------------------------------------------------------------------------
module brb_back #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [brb_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                     i_head_valid,
    input  brb_pkg::t_op             i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output brb_pkg::t_out_item       o_out_item,
    output brb_pkg::t_back_status    o_status
);
    import brb_pkg::*;

    localparam int               PTR_W   = $clog2(DEPTH);
    localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

    t_back_state       r_state, n_state;
    logic [CAP_W-1:0]  r_cap, n_cap;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_scan, n_scan;
    logic [CAP_W-1:0]  r_fill, n_fill;
    logic              r_burst_active, n_burst_active;
    logic              r_burst_ok, n_burst_ok;
    logic [CAP_W-1:0]  r_n, n_n;
    logic [CAP_W-1:0]  r_issued, n_issued;
    logic [CAP_W-1:0]  r_sent, n_sent;
    logic              r_take, n_take;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              out_free;
    logic              ram_we;
    logic              ram_rd_en;
    logic [BYTE_W-1:0] ram_rdata;
    logic              v_ok;
    logic [CAP_W-1:0]  v_n;
    logic [CAP_W-1:0]  v_cap;
    logic              v_last;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] nxt;
        nxt = CAP_W'(p) + CAP_W'(1);
        if (nxt >= cap) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_cap          = r_cap;
        n_rp           = r_rp;
        n_wp           = r_wp;
        n_scan         = r_scan;
        n_fill         = r_fill;
        n_burst_active = r_burst_active;
        n_burst_ok     = r_burst_ok;
        n_n            = r_n;
        n_issued       = r_issued;
        n_sent         = r_sent;
        n_take         = r_take;
        n_pend         = r_pend;
        n_out_valid    = r_out_valid;
        n_out          = r_out;
        o_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_rd_en      = 1'b0;
        v_ok           = 1'b0;
        v_n            = (i_head.length < r_fill) ? i_head.length : r_fill;
        v_cap          = i_cfg_wr_data;
        v_last         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.kind)
                        OP_APPEND: begin
                            if (!i_head.burst_end || out_free) begin
                                o_pop = 1'b1;
                                v_ok  = r_burst_ok;
                                if (!r_burst_active) begin
                                    v_ok = (i_head.need <= r_cap - r_fill);
                                end
                                if (v_ok) begin
                                    if (r_fill < r_cap) begin
                                        ram_we = 1'b1;
                                        n_wp   = step_ptr(r_wp, r_cap);
                                        n_fill = r_fill + CAP_W'(1);
                                    end else begin
                                        v_ok = 1'b0;
                                    end
                                end
                                if (i_head.burst_end) begin
                                    n_burst_active = 1'b0;
                                    n_burst_ok     = 1'b0;
                                    n_out_valid    = 1'b1;
                                    n_out          = '0;
                                    n_out.accepted = v_ok;
                                    n_out.last     = 1'b1;
                                end else begin
                                    n_burst_active = 1'b1;
                                    n_burst_ok     = v_ok;
                                end
                            end
                        end
                        OP_TAKE, OP_PEEK: begin
                            if (v_n == '0) begin
                                if (out_free) begin
                                    o_pop          = 1'b1;
                                    n_out_valid    = 1'b1;
                                    n_out          = '0;
                                    n_out.accepted = 1'b1;
                                    n_out.last     = 1'b1;
                                end
                            end else begin
                                o_pop    = 1'b1;
                                n_state  = BK_READ;
                                n_n      = v_n;
                                n_issued = '0;
                                n_sent   = '0;
                                n_scan   = r_rp;
                                n_pend   = 1'b0;
                                n_take   = (i_head.kind == OP_TAKE);
                                if (i_head.kind == OP_TAKE) begin
                                    n_fill = r_fill - v_n;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                if (r_pend && out_free) begin
                    v_last             = (r_sent + CAP_W'(1) == r_n);
                    n_out_valid        = 1'b1;
                    n_out.out_byte     = ram_rdata;
                    n_out.byte_valid   = 1'b1;
                    n_out.actual_count = r_n;
                    n_out.accepted     = 1'b1;
                    n_out.last         = v_last;
                    n_sent             = r_sent + CAP_W'(1);
                    if (v_last) begin
                        n_state = BK_IDLE;
                        if (r_take) begin
                            n_rp = r_scan;
                        end
                    end
                end
                if ((r_issued != r_n) && (!r_pend || out_free)) begin
                    ram_rd_en = 1'b1;
                    n_scan    = step_ptr(r_scan, r_cap);
                    n_issued  = r_issued + CAP_W'(1);
                end
                n_pend = ram_rd_en || (r_pend && !out_free);
            end
            default: n_state = BK_IDLE;
        endcase

        // Register write: clamp and empty the queue
        if (i_cfg_wr_en) begin
            if (v_cap == '0) begin
                v_cap = CAP_W'(1);
            end
            if (v_cap > DEPTH_C) begin
                v_cap = DEPTH_C;
            end
            n_cap          = v_cap;
            n_rp           = '0;
            n_wp           = '0;
            n_fill         = '0;
            n_burst_active = 1'b0;
            n_burst_ok     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BK_IDLE;
            r_cap          <= DEPTH_C;
            r_rp           <= '0;
            r_wp           <= '0;
            r_scan         <= '0;
            r_fill         <= '0;
            r_burst_active <= 1'b0;
            r_burst_ok     <= 1'b0;
            r_n            <= '0;
            r_issued       <= '0;
            r_sent         <= '0;
            r_take         <= 1'b0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cap          <= n_cap;
            r_rp           <= n_rp;
            r_wp           <= n_wp;
            r_scan         <= n_scan;
            r_fill         <= n_fill;
            r_burst_active <= n_burst_active;
            r_burst_ok     <= n_burst_ok;
            r_n            <= n_n;
            r_issued       <= n_issued;
            r_sent         <= n_sent;
            r_take         <= n_take;
            r_pend         <= n_pend;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_wp),
        .i_wr_data (i_head.data_byte),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_scan),
        .o_rd_data (ram_rdata)
    );

    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out;
    assign o_status.fill_count = r_fill;
    assign o_status.capacity   = r_cap;
    assign o_status.reading    = (r_state == BK_READ);

endmodule

// File: src/byte_ring_buffer_burst.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst: circular byte queue with burst append and counted reads
// Top level joining the decode front end, the operation queue and the
// execution back end that owns the byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one command
//   per transaction: an append byte, a take or a peek. An append burst is a
//   run of byte transactions; its first length is the burst size and the
//   burst is kept only if that many slots are free. Its final byte
//   (burst_end) returns one status transaction carrying the accepted flag.
//   A take or peek returns min(length, fill) byte transactions, the final
//   one marked last, or one status transaction when nothing can be read.
//   Output channel (o_out_valid / i_out_stall / o_out_item) holds a result
//   in its register while stalled; the front queue keeps accepting until
//   its two entries are full.
//   Timing: status is registered and appears in the cycle after the queue
//   hands it over. A read streams one byte per cycle while the output is
//   not stalled, set by the single read port of the store; the first byte
//   passes the state register, the store's read register and the result
//   register. Reset empties the queue and sets capacity to DEPTH. Writing
//   i_cfg_wr_data sets the capacity (clamped to 1..DEPTH) and empties the queue.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst #(
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [brb_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  brb_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output brb_pkg::t_out_item        o_out_item
);
    import brb_pkg::*;

    logic         head_valid;
    t_op          head;
    logic         pop;
    t_back_status status;

    // Front end: accept, decode and queue operations
    brb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back end: execute against the store and drive results
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .o_status      (status)
    );

`ifndef NO_ASSERTIONS
    a_fill_in_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill_count <= status.capacity)
        else $error("fill count exceeds capacity");

    a_capacity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.capacity != '0) && (status.capacity <= CAP_W'(DEPTH)))
        else $error("capacity out of range");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (status.fill_count == '0))
        else $error("register write did not empty the queue");

    a_no_pop_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.reading |-> !pop)
        else $error("operation taken while a read is streaming");
`endif

endmodule
